// ===== sv/uart_ring_buffer_pair_unit_defines.svh =====
// ---------------------------------------------------------------------------
// UART ring buffer pair: assertion macros
// Shared concurrent assertion helpers for the ring buffer pair RTL.
// ---------------------------------------------------------------------------
`ifndef UART_RING_BUFFER_PAIR_UNIT_DEFINES_SVH
`define UART_RING_BUFFER_PAIR_UNIT_DEFINES_SVH

// same-cycle implication
`define URB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define URB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/urb_pkg.sv =====
// ---------------------------------------------------------------------------
// urb_pkg
// Types and codes shared by the UART ring buffer pair modules.
// ---------------------------------------------------------------------------
package urb_pkg;

  typedef enum logic [1:0] {
    CMD_SERVICE = 2'd0,
    CMD_GET     = 2'd1,
    CMD_PUT     = 2'd2
  } cmd_e;

  // request into one ring
  typedef struct packed {
    logic push;
    logic pop;
  } ring_req_t;

  // status out of one ring
  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

  // result fields waiting on the RAM read
  typedef struct packed {
    logic ok;
    logic rx_pop;
    logic tx_pop;
    logic irq;
    logic ovf;
  } pend_t;

endpackage

// ===== sv/urb_ram.sv =====
// ---------------------------------------------------------------------------
// urb_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module urb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/urb_ring.sv =====
// ---------------------------------------------------------------------------
// urb_ring
// Circular FIFO control: write/read pointers, one slot kept empty, RAM store.
// ---------------------------------------------------------------------------
`include "uart_ring_buffer_pair_unit_defines.svh"

module urb_ring #(
  parameter int DEPTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  urb_pkg::ring_req_t req_i,
  input  logic [7:0]        wdata_i,
  output urb_pkg::ring_stat_t stat_o,
  output logic [7:0]        rdata_o
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic [AW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [AW-1:0] wptr_nxt, rptr_nxt;

  // pointers advance first, then the slot they land on is used
  assign wptr_nxt = (wptr_q == LastIdx) ? '0 : wptr_q + AW'(1);
  assign rptr_nxt = (rptr_q == LastIdx) ? '0 : rptr_q + AW'(1);

  assign stat_o.empty = (wptr_q == rptr_q);
  assign stat_o.full  = (wptr_nxt == rptr_q);

  always_comb begin
    wptr_d = req_i.push ? wptr_nxt : wptr_q;
    rptr_d = req_i.pop  ? rptr_nxt : rptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  urb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.push),
    .waddr_i (wptr_nxt),
    .wdata_i (wdata_i),
    .re_i    (req_i.pop),
    .raddr_i (rptr_nxt),
    .rdata_o (rdata_o)
  );

  `URB_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, req_i.push, !stat_o.full, "push on full ring")
  `URB_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, req_i.pop, !stat_o.empty, "pop on empty ring")

endmodule

// ===== sv/uart_ring_buffer_pair_unit.sv =====
// ---------------------------------------------------------------------------
// uart_ring_buffer_pair_unit
// UART receive and transmit ring buffers, serviced one command beat at a time.
// ---------------------------------------------------------------------------
//  channel | dir | handshake                 | payload
//  --------+-----+---------------------------+----------------------------------
//  in      | in  | in_valid_i / in_stall_o   | command, rx_ready, frame_error,
//          |     |                           | tx_empty, rx_byte, put_byte
//  out     | out | out_valid_o / out_stall_i | ok, got_byte, tx_write, tx_byte,
//          |     |                           | tx_irq_enabled, rx_overflow
//
// Flow: each beat goes from accept into pend, with its RAM read registered
//   alongside, then its read data moves into the output register.
//   A new beat is taken every cycle while the output register drains.
// Reset: pointers, irq enable and valids clear at once; no clearing pass.
// Stalls: a held output blocks the pending beat, which then holds in_stall_o.
// ---------------------------------------------------------------------------
`include "uart_ring_buffer_pair_unit_defines.svh"

module uart_ring_buffer_pair_unit #(
  parameter int RX_DEPTH = 16,
  parameter int TX_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input beats
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] command_i,
  input  logic       rx_ready_i,
  input  logic       frame_error_i,
  input  logic       tx_empty_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] put_byte_i,
  // result beats
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       ok_o,
  output logic [7:0] got_byte_o,
  output logic       tx_write_o,
  output logic [7:0] tx_byte_o,
  output logic       tx_irq_enabled_o,
  output logic       rx_overflow_o
);

  urb_pkg::ring_req_t  rx_req, tx_req;
  urb_pkg::ring_stat_t rx_stat, tx_stat;
  logic [7:0]          rx_rdata, tx_rdata;

  logic accept, out_load;
  logic pend_vld_q, pend_vld_d;
  urb_pkg::pend_t pend_q, pend_d;
  logic irq_q, irq_d;
  logic irq_set, irq_clr;
  logic rx_push, rx_pop, tx_push, tx_pop, ok, ovf;

  logic       out_vld_q, out_vld_d;
  logic       ok_q, tx_write_q, irq_out_q, ovf_q;
  logic [7:0] got_q, txb_q;

  // Handshake. A beat sits in pend until its RAM data lands in the output reg.
  assign out_load   = pend_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = pend_vld_q & ~out_load;
  assign accept     = in_valid_i & ~in_stall_o;

  // Command decode against current ring status.
  always_comb begin
    rx_push = 1'b0;
    rx_pop  = 1'b0;
    tx_push = 1'b0;
    tx_pop  = 1'b0;
    ok      = 1'b0;
    ovf     = 1'b0;
    irq_set = 1'b0;
    irq_clr = 1'b0;
    unique case (urb_pkg::cmd_e'(command_i))
      urb_pkg::CMD_SERVICE: begin
        // framed byte in: store it, or flag overflow when full
        if (rx_ready_i && !frame_error_i) begin
          rx_push = ~rx_stat.full;
          ovf     = rx_stat.full;
        end
        // transmitter free: hand over next byte, or quiet the irq
        if (tx_empty_i) begin
          tx_pop  = ~tx_stat.empty;
          irq_clr = tx_stat.empty;
        end
      end
      urb_pkg::CMD_GET: begin
        rx_pop = ~rx_stat.empty;
        ok     = ~rx_stat.empty;
      end
      urb_pkg::CMD_PUT: begin
        tx_push = ~tx_stat.full;
        ok      = ~tx_stat.full;
        irq_set = ~tx_stat.full;
      end
      default: begin
        // unused command code: nothing moves
      end
    endcase
  end

  // A beat never reads and writes the same RAM, and a read always targets a
  // slot written by an earlier beat, so no forwarding is needed.
  assign rx_req.push = accept & rx_push;
  assign rx_req.pop  = accept & rx_pop;
  assign tx_req.push = accept & tx_push;
  assign tx_req.pop  = accept & tx_pop;

  always_comb begin
    irq_d = irq_q;
    if (accept && irq_set) begin
      irq_d = 1'b1;
    end else if (accept && irq_clr) begin
      irq_d = 1'b0;
    end
  end

  always_comb begin
    pend_d.ok     = ok;
    pend_d.rx_pop = rx_pop;
    pend_d.tx_pop = tx_pop;
    pend_d.irq    = irq_d;
    pend_d.ovf    = ovf;
    pend_vld_d    = accept | (pend_vld_q & ~out_load);
    out_vld_d     = out_load | (out_vld_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      irq_q      <= irq_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload regs, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
    if (out_load) begin
      ok_q       <= pend_q.ok;
      got_q      <= pend_q.rx_pop ? rx_rdata : 8'd0;
      tx_write_q <= pend_q.tx_pop;
      txb_q      <= pend_q.tx_pop ? tx_rdata : 8'd0;
      irq_out_q  <= pend_q.irq;
      ovf_q      <= pend_q.ovf;
    end
  end

  urb_ring #(
    .DEPTH (RX_DEPTH)
  ) u_rx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (rx_req),
    .wdata_i (rx_byte_i),
    .stat_o  (rx_stat),
    .rdata_o (rx_rdata)
  );

  urb_ring #(
    .DEPTH (TX_DEPTH)
  ) u_tx_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (tx_req),
    .wdata_i (put_byte_i),
    .stat_o  (tx_stat),
    .rdata_o (tx_rdata)
  );

  assign out_valid_o      = out_vld_q;
  assign ok_o             = ok_q;
  assign got_byte_o       = got_q;
  assign tx_write_o       = tx_write_q;
  assign tx_byte_o        = txb_q;
  assign tx_irq_enabled_o = irq_out_q;
  assign rx_overflow_o    = ovf_q;

  `URB_ASSERT_NXT(a_accept_pends, clk_i, rst_ni, accept, pend_vld_q, "accepted beat not pending")
  `URB_ASSERT_NXT(a_pend_held, clk_i, rst_ni, pend_vld_q && !out_load, pend_vld_q, "pending beat lost")

endmodule
